>>> rtl/rc4sc_pkg.sv
// Shared types, constants and the control program of the RC4 stream cipher.
package rc4sc_pkg;

  // Default key store depth in bytes.
  localparam int unsigned RC4SC_MAX_KEY_BYTES = 256;

  // Permutation table geometry.
  localparam int unsigned RC4SC_PERM_DEPTH = 256;
  localparam int unsigned RC4SC_BYTE_W     = 8;

  // Item kinds carried in the op field.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Step codes of the control program.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_KEY      = 4'd1;
  localparam logic [STEP_W-1:0] ST_CLR      = 4'd2;
  localparam logic [STEP_W-1:0] ST_INIT     = 4'd3;
  localparam logic [STEP_W-1:0] ST_INIT_END = 4'd4;
  localparam logic [STEP_W-1:0] ST_K0       = 4'd5;
  localparam logic [STEP_W-1:0] ST_K1       = 4'd6;
  localparam logic [STEP_W-1:0] ST_K2       = 4'd7;
  localparam logic [STEP_W-1:0] ST_K3       = 4'd8;
  localparam logic [STEP_W-1:0] ST_K4       = 4'd9;
  localparam logic [STEP_W-1:0] ST_D0       = 4'd10;
  localparam logic [STEP_W-1:0] ST_D1       = 4'd11;
  localparam logic [STEP_W-1:0] ST_D2       = 4'd12;
  localparam logic [STEP_W-1:0] ST_D3       = 4'd13;

  // Input item.
  typedef struct packed {
    logic       op;
    logic [7:0] byte_in;
    logic       last_flag;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_message;
  } out_item_t;

  // Jump conditions; a false condition falls through to the next step.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_LAST,
    C_NOT_I_LAST,
    C_NOT_SCHED
  } cond_e;

  // Permutation write address.
  typedef enum logic {
    W_I,
    W_J
  } waddr_e;

  // Permutation read address.
  typedef enum logic [1:0] {
    R_I,
    R_I_INC,
    R_JNEW,
    R_T
  } raddr_e;

  // Permutation write data.
  typedef enum logic [1:0] {
    WD_I,
    WD_RDATA,
    WD_A
  } wdata_e;

  // Index i update.
  typedef enum logic [1:0] {
    I_HOLD,
    I_INC,
    I_CLR
  } iop_e;

  // Index j update.
  typedef enum logic [1:0] {
    J_HOLD,
    J_ADD,
    J_CLR
  } jop_e;

  // One control word of the program.
  typedef struct packed {
    logic              dispatch;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              pre;
    raddr_e            raddr;
    logic              pwe;
    waddr_e            waddr;
    wdata_e            wdata;
    logic              kre;
    logic              kwe;
    iop_e              iop;
    jop_e              jop;
    logic              jkey;
    logic              kidx_clr;
    logic              kidx_adv;
    logic              cnt_clr;
    logic              ld_a;
    logic              ld_b;
    logic              out_load;
  } ucw_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ucw_t w;
    logic adv;
    logic take;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic last;
    logic i_last;
    logic sched;
    logic out_busy;
  } stat_t;

  // Control program ROM.
  function automatic ucw_t rc4sc_ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.dispatch = 1'b1;
      end
      // Store the key byte; only the last one goes on to the schedule.
      ST_KEY: begin
        w.kwe    = 1'b1;
        w.cond   = C_NOT_LAST;
        w.target = ST_IDLE;
      end
      ST_CLR: begin
        w.iop = I_CLR;
        w.jop = J_CLR;
      end
      // Identity pass, one entry per cycle.
      ST_INIT: begin
        w.pwe      = 1'b1;
        w.waddr    = W_I;
        w.wdata    = WD_I;
        w.iop      = I_INC;
        w.kidx_clr = 1'b1;
        w.cond     = C_NOT_I_LAST;
        w.target   = ST_INIT;
      end
      ST_INIT_END: begin
        w.cond   = C_NOT_SCHED;
        w.target = ST_IDLE;
      end
      // Key schedule swap step.
      ST_K0: begin
        w.pre   = 1'b1;
        w.raddr = R_I;
        w.kre   = 1'b1;
      end
      ST_K1: begin
        w.ld_a     = 1'b1;
        w.jop      = J_ADD;
        w.jkey     = 1'b1;
        w.kidx_adv = 1'b1;
        w.pre      = 1'b1;
        w.raddr    = R_JNEW;
      end
      ST_K2: begin
        w.ld_b  = 1'b1;
        w.pwe   = 1'b1;
        w.waddr = W_I;
        w.wdata = WD_RDATA;
      end
      ST_K3: begin
        w.pwe    = 1'b1;
        w.waddr  = W_J;
        w.wdata  = WD_A;
        w.iop    = I_INC;
        w.cond   = C_NOT_I_LAST;
        w.target = ST_K0;
      end
      ST_K4: begin
        w.jop     = J_CLR;
        w.cnt_clr = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = ST_IDLE;
      end
      // Data byte: advance, swap, look up keystream byte.
      ST_D0: begin
        w.iop   = I_INC;
        w.pre   = 1'b1;
        w.raddr = R_I_INC;
      end
      ST_D1: begin
        w.ld_a  = 1'b1;
        w.jop   = J_ADD;
        w.pre   = 1'b1;
        w.raddr = R_JNEW;
      end
      ST_D2: begin
        w.ld_b  = 1'b1;
        w.pwe   = 1'b1;
        w.waddr = W_I;
        w.wdata = WD_RDATA;
        w.pre   = 1'b1;
        w.raddr = R_T;
      end
      ST_D3: begin
        w.pwe      = 1'b1;
        w.waddr    = W_J;
        w.wdata    = WD_A;
        w.out_load = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/rc4sc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rc4sc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rc4sc_seq.sv
// Step counter and control ROM sequencing the cipher datapath.
module rc4sc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  input  rc4sc_pkg::stat_t   stat_i,
  output logic               in_stall_o,
  output rc4sc_pkg::ctl_t    ctl_o
);
  import rc4sc_pkg::*;

  logic [STEP_W-1:0] upc_q, upc_d;
  ucw_t              cw;
  logic              adv;
  logic              take;
  logic              jump;

  assign cw = rc4sc_ucode(upc_q);

  // A step that loads the result waits while the output register is held.
  assign adv  = !(cw.out_load && stat_i.out_busy);
  assign take = cw.dispatch && in_valid_i;

  assign in_stall_o = !cw.dispatch;
  assign ctl_o.w    = cw;
  assign ctl_o.adv  = adv;
  assign ctl_o.take = take;

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (cw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NOT_LAST:   jump = !stat_i.last;
      C_NOT_I_LAST: jump = !stat_i.i_last;
      C_NOT_SCHED:  jump = !stat_i.sched;
      default:      jump = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    upc_d = upc_q;
    if (adv) begin
      if (cw.dispatch) begin
        if (take) begin
          upc_d = (in_op_i == OP_DATA) ? ST_D0 : ST_KEY;
        end
      end else if (jump) begin
        upc_d = cw.target;
      end else begin
        upc_d = upc_q + STEP_W'(1);
      end
    end
  end

  // Reset starts with the identity pass over the permutation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/rc4sc_dp.sv
// Cipher datapath: indices, key store, permutation RAM and output register.
module rc4sc_dp #(
  parameter int unsigned MaxKeyBytes = rc4sc_pkg::RC4SC_MAX_KEY_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rc4sc_pkg::ctl_t      ctl_i,
  input  rc4sc_pkg::in_item_t  in_data_i,
  input  logic                 out_stall_i,
  output rc4sc_pkg::stat_t     stat_o,
  output logic                 out_valid_o,
  output rc4sc_pkg::out_item_t out_data_o
);
  import rc4sc_pkg::*;

  localparam int unsigned KeyIdxW = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam int unsigned KeyCntW = $clog2(MaxKeyBytes + 1);

  ucw_t w;
  logic adv;

  logic [7:0]         i_q, i_d;
  logic [7:0]         j_q, j_d;
  logic [7:0]         a_q;
  logic [7:0]         b_q;
  logic [KeyIdxW-1:0] kidx_q, kidx_d;
  logic [KeyCntW-1:0] kcnt_q, kcnt_d;
  logic [KeyCntW-1:0] kcnt_m1;
  logic [KeyIdxW-1:0] klast;
  logic               key_room;
  logic               op_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;

  logic               pwe, pre;
  logic [7:0]         pwaddr, praddr, pwdata, prdata;
  logic               kwe, kre;
  logic [7:0]         krdata;
  logic [7:0]         jnew;
  logic [7:0]         t_rd;
  logic [7:0]         t_ks;
  logic [7:0]         kstream;

  assign w   = ctl_i.w;
  assign adv = ctl_i.adv;

  // New j: accumulates the table entry, plus the key byte during the schedule.
  assign jnew = j_q + prdata + (w.jkey ? krdata : 8'd0);
  assign t_rd = a_q + prdata;

  // Permutation RAM ports.
  assign pwe    = w.pwe && adv;
  assign pre    = w.pre && adv;
  assign pwaddr = (w.waddr == W_J) ? j_q : i_q;

  always_comb begin
    case (w.wdata)
      WD_I:     pwdata = i_q;
      WD_RDATA: pwdata = prdata;
      WD_A:     pwdata = a_q;
      default:  pwdata = a_q;
    endcase
  end

  always_comb begin
    case (w.raddr)
      R_I:     praddr = i_q;
      R_I_INC: praddr = i_q + 8'd1;
      R_JNEW:  praddr = jnew;
      R_T:     praddr = t_rd;
      default: praddr = i_q;
    endcase
  end

  rc4sc_ram #(
    .Width(RC4SC_BYTE_W),
    .Depth(RC4SC_PERM_DEPTH)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (pwe),
    .waddr_i(pwaddr),
    .wdata_i(pwdata),
    .re_i   (pre),
    .raddr_i(praddr),
    .rdata_o(prdata)
  );

  // Key store: written at the fill count, read at the repeating key index.
  assign key_room = kcnt_q < KeyCntW'(MaxKeyBytes);
  assign kwe      = w.kwe && adv && key_room;
  assign kre      = w.kre && adv;

  rc4sc_ram #(
    .Width(RC4SC_BYTE_W),
    .Depth(MaxKeyBytes),
    .AddrW(KeyIdxW)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (kwe),
    .waddr_i(kcnt_q[KeyIdxW-1:0]),
    .wdata_i(byte_q),
    .re_i   (kre),
    .raddr_i(kidx_q),
    .rdata_o(krdata)
  );

  // Last key index before wrapping; an empty key behaves as one byte.
  assign kcnt_m1 = kcnt_q - KeyCntW'(1);
  assign klast   = (kcnt_q == '0) ? '0 : kcnt_m1[KeyIdxW-1:0];

  // Index and counter updates.
  always_comb begin
    i_d = i_q;
    case (w.iop)
      I_HOLD:  i_d = i_q;
      I_INC:   i_d = i_q + 8'd1;
      I_CLR:   i_d = '0;
      default: i_d = i_q;
    endcase

    j_d = j_q;
    case (w.jop)
      J_HOLD:  j_d = j_q;
      J_ADD:   j_d = jnew;
      J_CLR:   j_d = '0;
      default: j_d = j_q;
    endcase

    kidx_d = kidx_q;
    if (w.kidx_clr) begin
      kidx_d = '0;
    end else if (w.kidx_adv) begin
      kidx_d = (kidx_q == klast) ? '0 : kidx_q + KeyIdxW'(1);
    end

    kcnt_d = kcnt_q;
    if (w.cnt_clr) begin
      kcnt_d = '0;
    end else if (kwe) begin
      kcnt_d = kcnt_q + KeyCntW'(1);
    end
  end

  // Keystream byte; entries swapped this item are taken from the registers.
  assign t_ks    = a_q + b_q;
  assign kstream = (t_ks == j_q) ? a_q : ((t_ks == i_q) ? b_q : prdata);

  // Output register frees when the receiver takes the item.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (w.out_load && adv) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      kcnt_q      <= '0;
      op_q        <= OP_DATA;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        i_q    <= i_d;
        j_q    <= j_d;
        kidx_q <= kidx_d;
        kcnt_q <= kcnt_d;
      end
      if (ctl_i.take) begin
        op_q <= in_data_i.op;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      byte_q <= in_data_i.byte_in;
      last_q <= in_data_i.last_flag;
    end
    if (adv && w.ld_a) begin
      a_q <= prdata;
    end
    if (adv && w.ld_b) begin
      b_q <= prdata;
    end
    if (adv && w.out_load) begin
      out_q.byte_out        <= byte_q ^ kstream;
      out_q.last_of_message <= last_q;
    end
  end

  assign stat_o.last     = last_q;
  assign stat_o.i_last   = (i_q == 8'hFF);
  assign stat_o.sched    = (op_q == OP_KEY);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher with a microcoded control sequencer.
//
//   Channel  Direction  Handshake               Payload
//   in       to block   in_valid_i / in_stall_o   in_item_t  (op, byte_in, last_flag)
//   out      from block out_valid_o / out_stall_i out_item_t (byte_out, last_of_message)
//
// A data item passes through steps D0 to D3 before the next acceptance; its result
// is registered in step D3. The read-swap-read chain on the single read port of
// the permutation RAM sets that sequence.
// A key item stores its byte in step KEY; the last key byte adds the schedule
// (a clear step, 256 identity writes, a check step, 256 swap steps, each made of
// the RAM steps K0 to K3, and a closing step).
// After reset the block fills the permutation with the identity, with in_stall_o
// high. A held result blocks only the step that writes the next one.
module rc4_stream_cipher_top #(
  parameter int unsigned MaxKeyBytes = rc4sc_pkg::RC4SC_MAX_KEY_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rc4sc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rc4sc_pkg::out_item_t out_data_o
);
  import rc4sc_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Program sequencer.
  rc4sc_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.op),
    .stat_i    (stat),
    .in_stall_o(in_stall_o),
    .ctl_o     (ctl)
  );

  // Datapath with the permutation and key stores.
  rc4sc_dp #(
    .MaxKeyBytes(MaxKeyBytes)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/rc4sc_chk.sv
// Port-level checker for the RC4 stream cipher, bound to the top level.
module rc4sc_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input rc4sc_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input rc4sc_pkg::out_item_t out_data_o
);
  import rc4sc_pkg::*;

  logic in_take;

  assign in_take = in_valid_i && !in_stall_o;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A data item occupies the block for the following cycle.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_data_i.op == OP_DATA) |=> in_stall_o)
    else $error("input taken again right after a data item");

  // A key item never produces a result.
  a_key_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_data_i.op == OP_KEY) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a key item");

  // A new result is written only while the input side is busy.
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a data item in flight");

endmodule

bind rc4_stream_cipher_top rc4sc_chk u_chk (.*);
